@@ hdl/mra_pkg.sv @@
`default_nettype none

package mra_pkg;

    // Field widths fixed by the item formats
    localparam int unsigned ADDR_BITS  = 32;
    localparam int unsigned BYTES_BITS = 17;
    localparam int unsigned DEPTH_BITS = 5;

    // Offsets are capped at 2^OFFSET_BITS; pool_size above that saturates
    localparam int unsigned OFFSET_BITS = 16;
    localparam logic [BYTES_BITS-1:0] LIMIT_CAP = BYTES_BITS'(1 << OFFSET_BITS);

    localparam logic [BYTES_BITS-1:0] POOL_SIZE_RESET = BYTES_BITS'(65536);

    // Action codes
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_ENTER = 2'd1;
    localparam logic [1:0] ACT_LEAVE = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_POOL  = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;
    localparam logic [1:0] ERR_EMPTY = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POOL_BASE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POOL_SIZE = 1'b1;

    typedef struct packed {
        logic [1:0]            action;
        logic [BYTES_BITS-1:0] request_size;
    } t_req;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  block_address;
        logic [1:0]            error;
        logic [BYTES_BITS-1:0] free_bytes;
        logic [BYTES_BITS-1:0] busy_bytes;
        logic [DEPTH_BITS-1:0] stack_depth;
        logic [BYTES_BITS-1:0] peak_bytes;
        logic [DEPTH_BITS-1:0] peak_depth;
    } t_res;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the item and read the top mark
        logic execute;   // apply the item and load the result register
    } t_ctl;

endpackage

`default_nettype wire

@@ hdl/mra_ctrl.sv @@
`default_nettype none

module mra_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    output logic             o_done,
    output mra_pkg::t_ctl    o_ctl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b0;
                end
            endcase
        end
    end

    assign o_ctl.capture = i_start && !r_busy;
    assign o_ctl.execute = (r_state == S_EXEC);
    assign o_busy        = r_busy;
    assign o_done        = r_done;

    // done only follows an execute cycle
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_EXEC))
        else $error("result strobe without execute cycle");

    // busy flag tracks the execute state
    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state == S_EXEC))
        else $error("busy flag out of step with state");

endmodule

`default_nettype wire

@@ hdl/mra_dp.sv @@
`default_nettype none

module mra_dp #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire mra_pkg::t_ctl                      i_ctl,
    input  wire mra_pkg::t_req                      i_req,
    input  wire logic                               i_cfg_valid,
    input  wire logic [mra_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [mra_pkg::ADDR_BITS-1:0]      i_cfg_data,
    output mra_pkg::t_res                           o_res
);

    localparam int unsigned TW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned BW = mra_pkg::BYTES_BITS;

    // Configuration
    logic [mra_pkg::ADDR_BITS-1:0] r_base;
    logic [BW-1:0]                 r_pool_size;

    // Allocator state
    logic [BW-1:0] r_offset;
    logic [TW-1:0] r_top;
    logic [BW-1:0] r_peak_busy;
    logic [TW-1:0] r_peak_stack;

    // Captured item and top mark
    logic [1:0]    r_action;
    logic [BW-1:0] r_size;
    logic [BW-1:0] r_mark;

    logic [BW-1:0] mem [STACK_DEPTH];

    mra_pkg::t_res r_res;

    logic [BW-1:0] n_offset;
    logic [TW-1:0] n_top;
    logic [BW-1:0] n_peak_busy;
    logic [TW-1:0] n_peak_stack;
    logic [1:0]    err;
    logic [mra_pkg::ADDR_BITS-1:0] addr;
    logic          push;
    logic [BW-1:0] limit;
    logic [BW:0]   sum;
    logic          fits;
    logic          stack_full;
    logic          stack_empty;
    logic [BW-1:0] free_bytes;
    logic [AW-1:0] rd_addr;

    assign rd_addr     = AW'(r_top - TW'(1));
    assign limit       = (r_pool_size > mra_pkg::LIMIT_CAP) ? mra_pkg::LIMIT_CAP : r_pool_size;
    assign sum         = (BW + 1)'(r_offset) + (BW + 1)'(r_size);
    assign fits        = (sum <= (BW + 1)'(limit));
    assign stack_full  = (r_top == TW'(STACK_DEPTH));
    assign stack_empty = (r_top == '0);

    always_comb begin
        n_offset     = r_offset;
        n_top        = r_top;
        n_peak_busy  = r_peak_busy;
        n_peak_stack = r_peak_stack;
        err          = mra_pkg::ERR_OK;
        addr         = '0;
        push         = 1'b0;
        case (r_action)
            mra_pkg::ACT_ALLOC: begin
                if (!fits) begin
                    err = mra_pkg::ERR_POOL;
                end else begin
                    addr     = r_base + mra_pkg::ADDR_BITS'(r_offset);
                    n_offset = sum[BW-1:0];
                    if (n_offset > r_peak_busy) begin
                        n_peak_busy = n_offset;
                    end
                end
            end
            mra_pkg::ACT_ENTER: begin
                if (stack_full) begin
                    err = mra_pkg::ERR_FULL;
                end else begin
                    push  = 1'b1;
                    n_top = r_top + TW'(1);
                    if (n_top > r_peak_stack) begin
                        n_peak_stack = n_top;
                    end
                end
            end
            mra_pkg::ACT_LEAVE: begin
                if (stack_empty) begin
                    err = mra_pkg::ERR_EMPTY;
                end else begin
                    n_top    = r_top - TW'(1);
                    n_offset = r_mark;
                end
            end
            default: begin
            end
        endcase
        free_bytes = (n_offset > limit) ? '0 : (limit - n_offset);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_pool_size  <= mra_pkg::POOL_SIZE_RESET;
            r_offset     <= '0;
            r_top        <= '0;
            r_peak_busy  <= '0;
            r_peak_stack <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mra_pkg::CFG_POOL_BASE: r_base      <= i_cfg_data;
                    mra_pkg::CFG_POOL_SIZE: r_pool_size <= i_cfg_data[BW-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_ctl.execute) begin
                r_offset     <= n_offset;
                r_top        <= n_top;
                r_peak_busy  <= n_peak_busy;
                r_peak_stack <= n_peak_stack;
            end
        end
    end

    // Captured item, mark memory and result register: no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_action <= i_req.action;
            r_size   <= i_req.request_size;
            r_mark   <= mem[rd_addr];
        end
        if (i_ctl.execute && push) begin
            mem[AW'(r_top)] <= r_offset;
        end
        if (i_ctl.execute) begin
            r_res.block_address <= addr;
            r_res.error         <= err;
            r_res.free_bytes    <= free_bytes;
            r_res.busy_bytes    <= n_offset;
            r_res.stack_depth   <= mra_pkg::DEPTH_BITS'(n_top);
            r_res.peak_bytes    <= n_peak_busy;
            r_res.peak_depth    <= mra_pkg::DEPTH_BITS'(n_peak_stack);
        end
    end

    assign o_res = r_res;

    // Every offset ever held, pushed marks included, is within the peak
    a_peak_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak_busy >= r_offset)
        else $error("busy bytes above recorded peak");

    a_peak_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak_stack >= r_top)
        else $error("stack depth above recorded peak");

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TW'(STACK_DEPTH))
        else $error("stack pointer past capacity");

    // State moves only while an item executes
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.execute |=> $stable(r_offset) && $stable(r_top))
        else $error("allocator state changed while idle");

endmodule

`default_nettype wire

@@ hdl/mark_release_arena_allocator_core.sv @@
//  Channel   Direction  Handshake                    Payload
//  request   in         start & !busy accepts        i_req  (action, request_size)
//  result    out        o_done, one cycle, no stall  o_res  (address, error, counters)
//  config    in         i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
//  On acceptance an item is latched and the top mark is read from the
//  context stack memory (registered read port); in the execute state it is
//  applied and the result register is loaded. o_done is high the cycle after.
//  A new item can be accepted in the same cycle that o_done is shown.
//  Reset is synchronous, active low; no clearing pass, marks are only used
//  after being pushed. The receiver cannot stall; config is always ready.
`default_nettype none

module mark_release_arena_allocator_core #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    // request channel
    input  wire logic                               start,
    output logic                                    busy,
    input  wire mra_pkg::t_req                      i_req,

    // result channel
    output logic                                    o_done,
    output mra_pkg::t_res                           o_res,

    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [mra_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [mra_pkg::ADDR_BITS-1:0]      i_cfg_data
);

    mra_pkg::t_ctl ctl;

    // Two-state sequencer: idle/accept, then execute
    mra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_ctl   (ctl)
    );

    // Offset, stack, peaks, config registers and the result register
    mra_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (o_res)
    );

    // Register writes go straight into the config registers, so the port never pushes back
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire
